// ----- rtl/core/tdt_pkg.sv -----
// Shared types and constants for the timer deadline table.
`timescale 1ns / 1ps
`default_nettype none
package tdt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int MAX_RES     = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int ID_W        = 16;
  localparam int TIME_W      = 48;
  localparam int IV_W        = 32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_COLLECT = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic again;
    logic flush_req;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/tdt_ctrl.sv -----
// Sequencer for table scans: load, scan, end-of-pass, collect flush.
`timescale 1ns / 1ps
`default_nettype none
module tdt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output tdt_pkg::cmd_t      cmd,
  input  tdt_pkg::sts_t      sts
);
  import tdt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        priority if (sts.again) state_nxt = S_SCAN;
        else if (sts.flush_req) state_nxt = S_FLUSH;
        else state_nxt = S_IDLE;
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN:  cmd.step  = 1'b1;
      S_FIN:   cmd.fin   = 1'b1;
      S_FLUSH: cmd.flush = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/tdt_dp.sv -----
// Timer table storage, scan accumulators and result register.
`timescale 1ns / 1ps
`default_nettype none
module tdt_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  tdt_pkg::cmd_t                cmd,
  output tdt_pkg::sts_t                sts,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [15:0]             in_timer_id,
  input  wire logic [47:0]             in_deadline,
  input  wire logic [31:0]             in_interval,
  input  wire logic [47:0]             in_now,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [15:0]                  out_fired_id,
  output logic                         out_fired,
  output logic                         out_earliest_changed,
  output logic [47:0]                  out_next_deadline,
  output logic                         out_deadline_valid,
  output logic                         out_last
);
  import tdt_pkg::*;

  // table
  logic [TABLE_DEPTH-1:0] valid_r, inb_r, mark_r, bm_r;
  logic                   open_r;
  logic [ID_W-1:0]        id_mem_r [TABLE_DEPTH];
  logic [TIME_W-1:0]      dl_mem_r [TABLE_DEPTH];
  logic [IV_W-1:0]        iv_mem_r [TABLE_DEPTH];

  // captured item
  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] dl_r, now_r;
  logic [IV_W-1:0]   iv_r;

  // scan state
  logic [IDX_W-1:0]  idx_r, best_idx_r, free_idx_r;
  logic              bf_r, ff_r, hit_r, pend_r;
  logic [TIME_W-1:0] best_dl_r;
  logic [ID_W-1:0]   best_id_r, pend_id_r;
  logic [CNT_W-1:0]  n_r;

  // result register
  logic              ov_r, ofd_r, oec_r, odv_r, olast_r;
  logic [1:0]        ost_r;
  logic [ID_W-1:0]   oid_r;
  logic [TIME_W-1:0] ond_r;

  logic [ID_W-1:0]   id_i;
  logic [TIME_W-1:0] dl_i, t_sat, cand_dl;
  logic [IV_W-1:0]   iv_i;
  logic [TIME_W:0]   sum;
  logic              live, rearm, cand_ok, take;
  logic [CNT_W-1:0]  n_inc;

  assign id_i  = id_mem_r[idx_r];
  assign dl_i  = dl_mem_r[idx_r];
  assign iv_i  = iv_mem_r[idx_r];
  assign live  = valid_r[idx_r] & ~inb_r[idx_r];
  assign sum   = {1'b0, now_r} + {{(TIME_W + 1 - IV_W){1'b0}}, iv_i};
  assign t_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign rearm = open_r & valid_r[idx_r] & inb_r[idx_r] & (iv_i != '0) & ~mark_r[idx_r];
  assign n_inc = n_r + 1'b1;

  always_comb begin
    cand_ok = 1'b0;
    cand_dl = dl_i;
    unique case (op_r)
      OP_ADD:     cand_ok = live;
      OP_CANCEL:  cand_ok = 1'b0;
      OP_COLLECT: cand_ok = live & (dl_i <= now_r);
      OP_FINISH: begin
        cand_ok = rearm | live;
        cand_dl = rearm ? t_sat : dl_i;
      end
      default:    cand_ok = 1'b0;
    endcase
  end

  assign take = cand_ok & (~bf_r | (cand_dl < best_dl_r));

  assign sts.scan_last = (idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.again     = (op_r == OP_COLLECT) & bf_r & (n_inc != CNT_W'(MAX_RES));
  assign sts.flush_req = (op_r == OP_COLLECT) & bf_r & (n_inc == CNT_W'(MAX_RES));

  // entry payload writes: add at end of pass, re-arm during finish scan
  always_ff @(posedge clk) begin
    if (cmd.fin && op_r == OP_ADD && ff_r) begin
      id_mem_r[free_idx_r] <= id_r;
      dl_mem_r[free_idx_r] <= dl_r;
      iv_mem_r[free_idx_r] <= iv_r;
    end else if (cmd.step && op_r == OP_FINISH && rearm) begin
      dl_mem_r[idx_r] <= t_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      id_r  <= in_timer_id;
      dl_r  <= in_deadline;
      iv_r  <= in_interval;
      now_r <= in_now;
    end
    if (cmd.step && take) begin
      best_dl_r  <= cand_dl;
      best_idx_r <= idx_r;
      best_id_r  <= id_i;
    end
    if (cmd.step && op_r == OP_ADD && !valid_r[idx_r] && !ff_r) begin
      free_idx_r <= idx_r;
    end
    if (cmd.fin && op_r == OP_COLLECT && bf_r) begin
      pend_id_r <= best_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      inb_r   <= '0;
      mark_r  <= '0;
      bm_r    <= '0;
      open_r  <= 1'b0;
      idx_r   <= '0;
      bf_r    <= 1'b0;
      ff_r    <= 1'b0;
      hit_r   <= 1'b0;
      pend_r  <= 1'b0;
      n_r     <= '0;
      ov_r    <= 1'b0;
      ost_r   <= ST_OK;
      oid_r   <= '0;
      ofd_r   <= 1'b0;
      oec_r   <= 1'b0;
      ond_r   <= '0;
      odv_r   <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cmd.load) begin
        idx_r  <= '0;
        bf_r   <= 1'b0;
        ff_r   <= 1'b0;
        hit_r  <= 1'b0;
        bm_r   <= '0;
        pend_r <= 1'b0;
        n_r    <= '0;
        if (op_t'(in_opcode) == OP_COLLECT && !open_r) begin
          mark_r <= '0;
          open_r <= 1'b1;
        end
      end

      if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
        if (take) bf_r <= 1'b1;
        unique case (op_r)
          OP_ADD: begin
            if (!valid_r[idx_r]) ff_r <= 1'b1;
          end
          OP_CANCEL: begin
            if (id_i == id_r) begin
              if (live) begin
                valid_r[idx_r] <= 1'b0;
                hit_r          <= 1'b1;
              end
              if (valid_r[idx_r] && inb_r[idx_r]) bm_r[idx_r] <= 1'b1;
            end
          end
          OP_COLLECT: ;
          OP_FINISH: begin
            if (open_r && valid_r[idx_r] && inb_r[idx_r]) begin
              inb_r[idx_r] <= 1'b0;
              if (!rearm) valid_r[idx_r] <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (cmd.fin) begin
        idx_r   <= '0;
        bf_r    <= 1'b0;
        ost_r   <= ST_OK;
        oid_r   <= '0;
        ofd_r   <= 1'b0;
        oec_r   <= 1'b0;
        ond_r   <= '0;
        odv_r   <= 1'b0;
        olast_r <= 1'b1;
        unique case (op_r)
          OP_ADD: begin
            ov_r <= 1'b1;
            if (!ff_r) begin
              ost_r <= ST_FULL;
            end else begin
              valid_r[free_idx_r] <= 1'b1;
              inb_r[free_idx_r]   <= 1'b0;
              mark_r[free_idx_r]  <= 1'b0;
              oec_r <= ~bf_r | (dl_r < best_dl_r);
            end
          end
          OP_CANCEL: begin
            ov_r <= 1'b1;
            if (!hit_r && open_r) mark_r <= mark_r | bm_r;
            if (!hit_r && !(open_r && (bm_r != '0))) ost_r <= ST_UNKNOWN;
          end
          OP_COLLECT: begin
            if (bf_r) begin
              inb_r[best_idx_r]  <= 1'b1;
              mark_r[best_idx_r] <= 1'b0;
              n_r    <= n_inc;
              pend_r <= 1'b1;
              // previous hit goes out now that another one follows
              if (pend_r) begin
                ov_r    <= 1'b1;
                oid_r   <= pend_id_r;
                ofd_r   <= 1'b1;
                olast_r <= 1'b0;
              end
            end else begin
              ov_r   <= 1'b1;
              pend_r <= 1'b0;
              if (pend_r) begin
                oid_r <= pend_id_r;
                ofd_r <= 1'b1;
              end
            end
          end
          OP_FINISH: begin
            ov_r <= 1'b1;
            if (open_r) begin
              mark_r <= '0;
              open_r <= 1'b0;
            end
            if (bf_r) begin
              ond_r <= best_dl_r;
              odv_r <= best_dl_r > now_r;
            end
          end
          default: ;
        endcase
      end

      if (cmd.flush) begin
        ov_r    <= 1'b1;
        ost_r   <= ST_OK;
        oid_r   <= pend_id_r;
        ofd_r   <= 1'b1;
        oec_r   <= 1'b0;
        ond_r   <= '0;
        odv_r   <= 1'b0;
        olast_r <= 1'b1;
        pend_r  <= 1'b0;
      end
    end
  end

  assign out_valid            = ov_r;
  assign out_status           = ost_r;
  assign out_fired_id         = oid_r;
  assign out_fired            = ofd_r;
  assign out_earliest_changed = oec_r;
  assign out_next_deadline    = ond_r;
  assign out_deadline_valid   = odv_r;
  assign out_last             = olast_r;

endmodule
`default_nettype wire

// ----- rtl/core/timer_deadline_table.sv -----
// Top level of the timer deadline table.
`timescale 1ns / 1ps
`default_nettype none
// Commands are taken when start is high and busy is low. Add, cancel and
// finish each run a load step, a scan over every table slot and a step
// that closes the pass, in which the single result beat is registered.
// Collect runs one full scan per expired timer plus a closing scan, each
// followed by a step that closes the pass. When the 32-timer limit is
// reached the closing scan is replaced by a single flush step for the last
// beat. Every result beat is shown for one cycle with out_valid high and
// cannot be held off; the receiver must take it then. out_last marks the
// final beat of a command.
module timer_deadline_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_timer_id,
  input  wire logic [47:0] in_deadline,
  input  wire logic [31:0] in_interval,
  input  wire logic [47:0] in_now,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_fired_id,
  output logic             out_fired,
  output logic             out_earliest_changed,
  output logic [47:0]      out_next_deadline,
  output logic             out_deadline_valid,
  output logic             out_last
);
  import tdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tdt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  tdt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_timer_id          (in_timer_id),
    .in_deadline          (in_deadline),
    .in_interval          (in_interval),
    .in_now               (in_now),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_fired_id         (out_fired_id),
    .out_fired            (out_fired),
    .out_earliest_changed (out_earliest_changed),
    .out_next_deadline    (out_next_deadline),
    .out_deadline_valid   (out_deadline_valid),
    .out_last             (out_last)
  );

endmodule
`default_nettype wire
